>>> rtl/core/rwst_pkg.sv
// ----------------------------------------------------------------------------
// rwst_pkg
// Shared types and constants of the retransmit window slot table.
// ----------------------------------------------------------------------------
package rwst_pkg;

  // Number of slots in the window storage.
  localparam int WINDOW_DEPTH = 32;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  // Width used for window and held comparisons.
  localparam int CMP_W        = 10;
  // Scans list at most this many chunks.
  localparam int MAX_RESULTS  = 32;
  localparam int RES_W        = 6;
  // Eviction and urgency thresholds on the retry count.
  localparam logic [7:0] EVICT_RETRIES  = 8'd3;
  localparam logic [7:0] URGENT_RETRIES = 8'd5;
  localparam logic [7:0] RETRY_MAX      = 8'd255;

  typedef enum logic [2:0] {
    KIND_ACQUIRE  = 3'd0,
    KIND_MARK     = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_TO_SCAN  = 3'd4,
    KIND_RT_SCAN  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] chunk_id;
    logic [9:0]  missing_count;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] result_chunk;
    logic        evicted;
    logic [31:0] evicted_chunk;
    logic        urgent;
    logic [5:0]  free_slots;
    logic        last;
  } out_word_t;

  // One slot record in the slot memory.
  typedef struct packed {
    logic [31:0] chunk;
    logic [31:0] sent_tick;
    logic        needs_resend;
    logic [7:0]  retries;
    logic [9:0]  missing;
  } slot_rec_t;

  // Commands to the age list.
  typedef struct packed {
    logic              push;
    logic [SLOT_W-1:0] push_slot;
    logic              remove;
    logic [SLOT_W-1:0] remove_pos;
  } age_cmd_t;

endpackage

>>> rtl/core/retransmit_window_slot_table_core.sv
// ----------------------------------------------------------------------------
// retransmit_window_slot_table_core
// Retransmission window scoreboard: grants sequential chunk ids, flags,
// frees and scans outstanding chunks held in a slot memory.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | in_word_t (kind, id, missing)
//   out_    | output    | out_valid/out_stall| out_word_t
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Tick and unknown items go from ST_IDLE straight to ST_FIN. Walking items read
// the slot memory at most once per held slot, in ST_RD and then ST_EV; the walk
// over the age list sets how long they take.
// Reset is synchronous and clears the window; no clearing pass is needed.
// A stalled result holds the walk; one result word is kept in reserve.
// ----------------------------------------------------------------------------
module retransmit_window_slot_table_core
  import rwst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RD    = 5'b00010,
    ST_EV    = 5'b00100,
    ST_GRANT = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [31:0]        cid_r, cid_nxt;
  logic [9:0]         miss_r, miss_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt;
  logic [SLOT_W-1:0]  s_r, s_nxt;
  logic               found_r, found_nxt;
  logic               ev_r, ev_nxt;
  logic [31:0]        evc_r, evc_nxt;
  logic [31:0]        res_r, res_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [31:0]        pend_r, pend_nxt;
  logic [RES_W:0]     cnt_r, cnt_nxt;
  logic [31:0]        next_chunk_r, next_chunk_nxt;
  logic [31:0]        now_r, now_nxt;
  logic               urgent_r, urgent_nxt;
  logic [5:0]         ws_r;
  logic [31:0]        to_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  age_cmd_t           cmd;
  logic [SLOT_W-1:0]  rd_slot;
  logic [CNT_W-1:0]   held;
  logic               free_ok;
  logic [SLOT_W-1:0]  free_slot;

  logic               mem_we, mem_re;
  logic [SLOT_W-1:0]  mem_waddr;
  slot_rec_t          mem_wdata, mem_rdata;

  logic [CMP_W-1:0]   held_x, ws_x, lim_x;
  logic               full, out_free;
  logic [5:0]         free_cnt;
  logic [7:0]         retry_inc;
  logic [31:0]        age;

  rwst_age_list u_age (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_pos    (p_r[SLOT_W-1:0]),
    .rd_slot   (rd_slot),
    .held      (held),
    .free_ok   (free_ok),
    .free_slot (free_slot)
  );

  rwst_ram #(
    .DW ($bits(slot_rec_t)),
    .AW (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_slot),
    .rdata (mem_rdata)
  );

  // Window limit and free count.
  always_comb begin
    held_x   = CMP_W'(held);
    ws_x     = CMP_W'(ws_r);
    lim_x    = (ws_x > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : ws_x;
    full     = (held_x >= lim_x);
    free_cnt = (held_x >= ws_x) ? 6'd0 : 6'(ws_x - held_x);
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign retry_inc = (mem_rdata.retries < RETRY_MAX) ? mem_rdata.retries + 8'd1
                                                    : mem_rdata.retries;
  assign age       = now_r - mem_rdata.sent_tick;

  // Sequencer over the age list.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cid_nxt        = cid_r;
    miss_nxt       = miss_r;
    p_nxt          = p_r;
    s_nxt          = s_r;
    found_nxt      = found_r;
    ev_nxt         = ev_r;
    evc_nxt        = evc_r;
    res_nxt        = res_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    next_chunk_nxt = next_chunk_r;
    now_nxt        = now_r;
    urgent_nxt     = urgent_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    cmd            = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = s_r;
    mem_wdata      = mem_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_word.kind;
          cid_nxt    = in_word.chunk_id;
          miss_nxt   = in_word.missing_count;
          p_nxt      = '0;
          found_nxt  = 1'b0;
          ev_nxt     = 1'b0;
          evc_nxt    = '0;
          res_nxt    = '0;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          case (in_word.kind)
            KIND_ACQUIRE: state_nxt = full ? ST_RD : ST_GRANT;
            KIND_MARK, KIND_COMPLETE, KIND_TO_SCAN, KIND_RT_SCAN: state_nxt = ST_RD;
            KIND_TICK: begin
              now_nxt   = now_r + 32'd1;
              state_nxt = ST_FIN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_RD: begin
        if (p_r >= held || cnt_r == (RES_W+1)'(MAX_RESULTS)) begin
          state_nxt = (kind_r == KIND_ACQUIRE) ? ST_GRANT : ST_FIN;
        end else begin
          mem_re    = 1'b1;
          s_nxt     = rd_slot;
          state_nxt = ST_EV;
        end
      end

      ST_EV: begin
        case (kind_r)
          KIND_ACQUIRE: begin
            if (mem_rdata.needs_resend && mem_rdata.retries > EVICT_RETRIES) begin
              ev_nxt         = 1'b1;
              evc_nxt        = mem_rdata.chunk;
              cmd.remove     = 1'b1;
              cmd.remove_pos = p_r[SLOT_W-1:0];
              state_nxt      = ST_GRANT;
            end else begin
              p_nxt     = p_r + CNT_W'(1);
              state_nxt = ST_RD;
            end
          end
          KIND_MARK: begin
            if (mem_rdata.chunk == cid_r) begin
              mem_we                 = 1'b1;
              mem_wdata.needs_resend = 1'b1;
              mem_wdata.missing      = miss_r;
              mem_wdata.retries      = retry_inc;
              if (retry_inc > URGENT_RETRIES) begin
                urgent_nxt = 1'b1;
              end
              found_nxt = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              p_nxt     = p_r + CNT_W'(1);
              state_nxt = ST_RD;
            end
          end
          KIND_COMPLETE: begin
            // A match closes the gap, so the same position is read again.
            if (mem_rdata.chunk == cid_r) begin
              cmd.remove     = 1'b1;
              cmd.remove_pos = p_r[SLOT_W-1:0];
              found_nxt      = 1'b1;
            end else begin
              p_nxt = p_r + CNT_W'(1);
            end
            state_nxt = ST_RD;
          end
          default: begin
            // Scans keep one listed chunk in reserve to mark the final word.
            logic pick;
            pick = (kind_r == KIND_TO_SCAN) ?
                   (!mem_rdata.needs_resend && age > to_r) :
                   (mem_rdata.needs_resend && mem_rdata.missing != 10'd0);
            if (!pick) begin
              p_nxt     = p_r + CNT_W'(1);
              state_nxt = ST_RD;
            end else if (!pend_v_r || out_free) begin
              if (pend_v_r) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = '{hit: 1'b1, result_chunk: pend_r, evicted: 1'b0,
                                  evicted_chunk: '0, urgent: urgent_r,
                                  free_slots: free_cnt, last: 1'b0};
              end
              pend_v_nxt = 1'b1;
              pend_nxt   = mem_rdata.chunk;
              cnt_nxt    = cnt_r + (RES_W+1)'(1);
              p_nxt      = p_r + CNT_W'(1);
              state_nxt  = ST_RD;
            end
          end
        endcase
      end

      ST_GRANT: begin
        if (!full && free_ok) begin
          mem_we              = 1'b1;
          mem_waddr           = free_slot;
          mem_wdata.chunk     = next_chunk_r;
          mem_wdata.sent_tick = now_r;
          mem_wdata.needs_resend = 1'b0;
          mem_wdata.retries   = 8'd0;
          mem_wdata.missing   = 10'd0;
          cmd.push            = 1'b1;
          cmd.push_slot       = free_slot;
          found_nxt           = 1'b1;
          res_nxt             = next_chunk_r;
          next_chunk_nxt      = next_chunk_r + 32'd1;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_TO_SCAN || kind_r == KIND_RT_SCAN) begin
            out_word_nxt = '{hit: pend_v_r, result_chunk: pend_v_r ? pend_r : 32'd0,
                             evicted: 1'b0, evicted_chunk: '0, urgent: urgent_r,
                             free_slots: free_cnt, last: 1'b1};
          end else begin
            out_word_nxt = '{hit: found_r, result_chunk: res_r, evicted: ev_r,
                             evicted_chunk: evc_r, urgent: urgent_r,
                             free_slots: free_cnt, last: 1'b1};
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_chunk_r <= '0;
      now_r        <= '0;
      urgent_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      ws_r         <= 6'd32;
      to_r         <= 32'd1000;
    end else begin
      state_r      <= state_nxt;
      next_chunk_r <= next_chunk_nxt;
      now_r        <= now_nxt;
      urgent_r     <= urgent_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:   ws_r <= cfg_data[5:0];
          CFG_TIMEOUT_TICKS: to_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Per-item working registers and the result word.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    cid_r      <= cid_nxt;
    miss_r     <= miss_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    found_r    <= found_nxt;
    ev_r       <= ev_nxt;
    evc_r      <= evc_nxt;
    res_r      <= res_nxt;
    pend_v_r   <= pend_v_nxt;
    pend_r     <= pend_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

>>> rtl/core/rwst_ram.sv
// ----------------------------------------------------------------------------
// rwst_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rwst_ram #(
  parameter int DW = 8,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rwst_age_list.sv
// ----------------------------------------------------------------------------
// rwst_age_list
// Slots held in acquisition order, slot occupancy bits and the held count.
// ----------------------------------------------------------------------------
module rwst_age_list
  import rwst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  age_cmd_t          cmd,
  input  logic [SLOT_W-1:0] rd_pos,
  output logic [SLOT_W-1:0] rd_slot,
  output logic [CNT_W-1:0]  held,
  output logic              free_ok,
  output logic [SLOT_W-1:0] free_slot
);

  logic [SLOT_W-1:0]       order_r [0:WINDOW_DEPTH-1];
  logic [WINDOW_DEPTH-1:0] used_r;
  logic [CNT_W-1:0]        held_r;

  assign rd_slot = order_r[rd_pos];
  assign held    = held_r;

  // Lowest free slot.
  always_comb begin
    free_ok   = 1'b0;
    free_slot = '0;
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok   = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Order list: removal closes the gap, push appends at the tail.
  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
        if (SLOT_W'(k) >= cmd.remove_pos) begin
          order_r[k] <= order_r[k+1];
        end
      end
    end else if (cmd.push) begin
      order_r[held_r[SLOT_W-1:0]] <= cmd.push_slot;
    end
  end

  // Occupancy and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      held_r <= '0;
    end else if (cmd.remove) begin
      used_r[order_r[cmd.remove_pos]] <= 1'b0;
      held_r <= held_r - CNT_W'(1);
    end else if (cmd.push) begin
      used_r[cmd.push_slot] <= 1'b1;
      held_r <= held_r + CNT_W'(1);
    end
  end

endmodule
